### design/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS_DEF = 12;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ZONE_0 = 3'd0,
        ZONE_1 = 3'd1,
        ZONE_2 = 3'd2,
        ZONE_3 = 3'd3,
        ZONE_4 = 3'd4,
        ZONE_5 = 3'd5,
        ZONE_6 = 3'd6,
        ZONE_7 = 3'd7
    } t_zone;

endpackage

### design/midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top - eight-zone midpoint line rasterizer
// A step request's pixel is registered in main, or in skid if main is stalled.
// One request per cycle while the skid is empty; step: add, compare, zone map.
// A two-entry output stage (main + skid) keeps o_s_tready a registered signal.
// Reset (sync, active low) drops the active line and empties the output stage.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top #(
    parameter  int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
    localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // x_start, y_start, x_end, y_end
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // action
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // pixel_x, pixel_y
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // octant
    output logic [2:0]             o_m_tuser,
    // last_point
    output logic                   o_m_tlast
);

    localparam int N = COORD_BITS;
    localparam int W = N + 1;   // zone-0 walk coordinates
    localparam int E = N + 2;   // east increment
    localparam int D = N + 3;   // decision and north-east increment

    typedef struct packed {
        logic signed [N-1:0] x;
        logic signed [N-1:0] y;
        mlr_pkg::t_zone      zone;
        logic                last;
    } t_pix;

    function automatic logic [2*W-1:0] to_zone0(input mlr_pkg::t_zone z,
                                                input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y);
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
        case (z)
            mlr_pkg::ZONE_0: begin ox = x;  oy = y;  end
            mlr_pkg::ZONE_1: begin ox = y;  oy = x;  end
            mlr_pkg::ZONE_2: begin ox = y;  oy = -x; end
            mlr_pkg::ZONE_3: begin ox = -x; oy = y;  end
            mlr_pkg::ZONE_4: begin ox = -x; oy = -y; end
            mlr_pkg::ZONE_5: begin ox = -y; oy = -x; end
            mlr_pkg::ZONE_6: begin ox = -y; oy = x;  end
            default:         begin ox = x;  oy = -y; end
        endcase
        return {oy, ox};
    endfunction

    function automatic logic [2*W-1:0] from_zone0(input mlr_pkg::t_zone z,
                                                  input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
        case (z)
            mlr_pkg::ZONE_0: begin ox = x;  oy = y;  end
            mlr_pkg::ZONE_1: begin ox = y;  oy = x;  end
            mlr_pkg::ZONE_2: begin ox = -y; oy = x;  end
            mlr_pkg::ZONE_3: begin ox = -x; oy = y;  end
            mlr_pkg::ZONE_4: begin ox = -x; oy = -y; end
            mlr_pkg::ZONE_5: begin ox = -y; oy = -x; end
            mlr_pkg::ZONE_6: begin ox = y;  oy = -x; end
            default:         begin ox = x;  oy = -y; end
        endcase
        return {oy, ox};
    endfunction

    // line state
    mlr_pkg::t_zone      r_zone,       n_zone;
    logic signed [W-1:0] r_walk_x,     n_walk_x;
    logic signed [W-1:0] r_walk_y,     n_walk_y;
    logic signed [W-1:0] r_stop_x,     n_stop_x;
    logic signed [D-1:0] r_decision,   n_decision;
    logic signed [E-1:0] r_east,       n_east;
    logic signed [D-1:0] r_ne,         n_ne;
    logic                r_active,     n_active;
    logic                r_start_sent, n_start_sent;

    // output stage
    logic r_main_valid;
    logic r_skid_valid;
    t_pix r_main;
    t_pix r_skid;

    logic                accept;
    logic                produce;
    logic                take;
    t_pix                pix;

    // load path
    logic signed [W-1:0] x1, y1, x2, y2;
    logic signed [W-1:0] dx, dy;
    logic        [W-1:0] ax, ay, dxp, dyp;
    logic                x_major;
    mlr_pkg::t_zone      ld_zone;
    logic        [2*W-1:0] start_map;
    logic        [2*W-1:0] end_map;
    logic signed [D-1:0] dxp_d, dyp_d;
    logic signed [D-1:0] east_d;

    // step path
    logic                adv;
    logic                go_east;
    logic        [2*W-1:0] out_map;

    assign take       = r_main_valid && i_m_tready;
    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign produce    = accept && (i_s_tuser == mlr_pkg::ACT_STEP) && r_active;

    always_comb begin
        x1 = $signed({i_s_tdata[N-1],   i_s_tdata[N-1:0]});
        y1 = $signed({i_s_tdata[2*N-1], i_s_tdata[2*N-1:N]});
        x2 = $signed({i_s_tdata[3*N-1], i_s_tdata[3*N-1:2*N]});
        y2 = $signed({i_s_tdata[4*N-1], i_s_tdata[4*N-1:3*N]});
        dx = x2 - x1;
        dy = y2 - y1;
        ax = dx[W-1] ? W'(-dx) : W'(dx);
        ay = dy[W-1] ? W'(-dy) : W'(dy);
        x_major = ax > ay;
        if (!dx[W-1] && !dy[W-1]) begin
            ld_zone = x_major ? mlr_pkg::ZONE_0 : mlr_pkg::ZONE_1;
        end else if (!dx[W-1]) begin
            ld_zone = x_major ? mlr_pkg::ZONE_7 : mlr_pkg::ZONE_6;
        end else if (dy[W-1]) begin
            ld_zone = x_major ? mlr_pkg::ZONE_4 : mlr_pkg::ZONE_5;
        end else begin
            ld_zone = x_major ? mlr_pkg::ZONE_3 : mlr_pkg::ZONE_2;
        end
        // zone-0 deltas are the major and minor magnitudes
        dxp    = x_major ? ax : ay;
        dyp    = x_major ? ay : ax;
        dxp_d  = $signed({2'b00, dxp});
        dyp_d  = $signed({2'b00, dyp});
        east_d = dyp_d <<< 1;
        start_map = to_zone0(ld_zone, x1, y1);
        end_map   = to_zone0(ld_zone, x2, y2);
    end

    always_comb begin
        adv     = r_start_sent && (r_walk_x < r_stop_x);
        go_east = r_decision[D-1];

        n_zone       = r_zone;
        n_walk_x     = r_walk_x;
        n_walk_y     = r_walk_y;
        n_stop_x     = r_stop_x;
        n_decision   = r_decision;
        n_east       = r_east;
        n_ne         = r_ne;
        n_active     = r_active;
        n_start_sent = r_start_sent;

        if (adv) begin
            n_walk_x = r_walk_x + W'(1);
            if (go_east) begin
                n_decision = r_decision + $signed({r_east[E-1], r_east});
            end else begin
                n_walk_y   = r_walk_y + W'(1);
                n_decision = r_decision + r_ne;
            end
        end

        out_map  = from_zone0(r_zone, n_walk_x, n_walk_y);
        pix.x    = out_map[N-1:0];
        pix.y    = out_map[W+N-1:W];
        pix.zone = r_zone;
        pix.last = n_walk_x >= r_stop_x;

        if (accept && (i_s_tuser == mlr_pkg::ACT_LOAD)) begin
            n_zone       = ld_zone;
            n_walk_x     = start_map[W-1:0];
            n_walk_y     = start_map[2*W-1:W];
            n_stop_x     = end_map[W-1:0];
            n_decision   = east_d - dxp_d;
            n_east       = east_d[E-1:0];
            n_ne         = (dyp_d - dxp_d) <<< 1;
            n_active     = 1'b1;
            n_start_sent = 1'b0;
        end else if (produce) begin
            n_active     = !pix.last;
            n_start_sent = 1'b1;
        end else begin
            n_walk_x   = r_walk_x;
            n_walk_y   = r_walk_y;
            n_decision = r_decision;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zone     <= n_zone;
        r_walk_x   <= n_walk_x;
        r_walk_y   <= n_walk_y;
        r_stop_x   <= n_stop_x;
        r_decision <= n_decision;
        r_east     <= n_east;
        r_ne       <= n_ne;
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_start_sent <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_start_sent <= n_start_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (produce) begin
            if (!r_main_valid || take) begin
                r_main       <= pix;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= pix;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_main_valid <= 1'b0;
        end
    end

    always_comb begin
        o_m_tdata          = '0;
        o_m_tdata[N-1:0]   = r_main.x;
        o_m_tdata[2*N-1:N] = r_main.y;
    end

    assign o_m_tvalid = r_main_valid;
    assign o_m_tuser  = r_main.zone;
    assign o_m_tlast  = r_main.last;

endmodule

### design/mlr_checker.sv
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks for the midpoint line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mlr_checker #(
    parameter  int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic [2:0]             o_m_tuser,
    input logic                   o_m_tlast
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("master tvalid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("master payload changed while stalled");

    // a load request never yields a pixel
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == mlr_pkg::ACT_LOAD) && !o_m_tvalid
            |=> !o_m_tvalid)
        else $error("pixel emitted after a load request");

    // back-pressure only when both output entries are full
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("slave tready low with empty output");

endmodule

bind midpoint_line_rasterizer_top mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (.*);

### dv/tb_midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// tb_midpoint_line_rasterizer_top
// Self-checking bench for the eight-zone midpoint line rasterizer. Load and
// step requests go in on the slave stream. A scoreboard walks each line in
// zone 0 and maps every pixel back to its zone. Each pixel on the master
// stream is compared field by field with the oldest predicted pixel. Both
// sides idle at random. The sender holds off now and then until every
// predicted pixel has come back.
// ----------------------------------------------------------------------------
module tb_midpoint_line_rasterizer_top;

    localparam int COORD_W     = mlr_pkg::COORD_BITS_DEF;
    localparam int IN_W        = ((4 * COORD_W + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * COORD_W + 7) / 8) * 8;
    localparam int ITEM_TARGET = 750;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        mlr_pkg::t_zone     zone;
        logic               last;
    } t_pixel;

    class pixel_scoreboard;
        mlr_pkg::t_zone     zone;
        logic signed [12:0] walk_x;
        logic signed [12:0] walk_y;
        logic signed [12:0] stop_x;
        logic signed [14:0] decision;
        logic signed [13:0] east_step;
        logic signed [14:0] diag_step;
        bit                 drawing;
        bit                 origin_sent;
        t_pixel             pending_q[$];
        int                 mismatches;

        function new();
            zone        = mlr_pkg::ZONE_0;
            walk_x      = '0;
            walk_y      = '0;
            stop_x      = '0;
            decision    = '0;
            east_step   = '0;
            diag_step   = '0;
            drawing     = 1'b0;
            origin_sent = 1'b0;
            mismatches  = 0;
        endfunction

        function mlr_pkg::t_zone pick_zone(int dx, int dy);
            int ax;
            int ay;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (dx >= 0 && dy >= 0) return (ax > ay) ? mlr_pkg::ZONE_0 : mlr_pkg::ZONE_1;
            if (dx >= 0) return (ax > ay) ? mlr_pkg::ZONE_7 : mlr_pkg::ZONE_6;
            if (dy < 0) return (ax > ay) ? mlr_pkg::ZONE_4 : mlr_pkg::ZONE_5;
            return (ax > ay) ? mlr_pkg::ZONE_3 : mlr_pkg::ZONE_2;
        endfunction

        function void fold(mlr_pkg::t_zone z, int x, int y, output int fx, output int fy);
            case (z)
                mlr_pkg::ZONE_0: begin fx = x;  fy = y;  end
                mlr_pkg::ZONE_1: begin fx = y;  fy = x;  end
                mlr_pkg::ZONE_2: begin fx = y;  fy = -x; end
                mlr_pkg::ZONE_3: begin fx = -x; fy = y;  end
                mlr_pkg::ZONE_4: begin fx = -x; fy = -y; end
                mlr_pkg::ZONE_5: begin fx = -y; fy = -x; end
                mlr_pkg::ZONE_6: begin fx = -y; fy = x;  end
                default: begin fx = x; fy = -y; end
            endcase
        endfunction

        function void unfold(mlr_pkg::t_zone z, int x, int y, output int ux, output int uy);
            case (z)
                mlr_pkg::ZONE_0: begin ux = x;  uy = y;  end
                mlr_pkg::ZONE_1: begin ux = y;  uy = x;  end
                mlr_pkg::ZONE_2: begin ux = -y; uy = x;  end
                mlr_pkg::ZONE_3: begin ux = -x; uy = y;  end
                mlr_pkg::ZONE_4: begin ux = -x; uy = -y; end
                mlr_pkg::ZONE_5: begin ux = -y; uy = -x; end
                mlr_pkg::ZONE_6: begin ux = y;  uy = -x; end
                default: begin ux = x; uy = -y; end
            endcase
        endfunction

        function void note_request(mlr_pkg::t_action act, logic [IN_W-1:0] data);
            int     x0, y0, x1, y1;
            int     sx, sy, ex, ey;
            int     px, py;
            t_pixel want;
            if (act == mlr_pkg::ACT_LOAD) begin
                x0 = $signed(data[COORD_W-1:0]);
                y0 = $signed(data[2*COORD_W-1:COORD_W]);
                x1 = $signed(data[3*COORD_W-1:2*COORD_W]);
                y1 = $signed(data[4*COORD_W-1:3*COORD_W]);
                zone = pick_zone(x1 - x0, y1 - y0);
                fold(zone, x0, y0, sx, sy);
                fold(zone, x1, y1, ex, ey);
                walk_x      = 13'(sx);
                walk_y      = 13'(sy);
                stop_x      = 13'(ex);
                decision    = 15'(2 * (ey - sy) - (ex - sx));
                east_step   = 14'(2 * (ey - sy));
                diag_step   = 15'(2 * ((ey - sy) - (ex - sx)));
                drawing     = 1'b1;
                origin_sent = 1'b0;
                return;
            end
            if (!drawing) return;
            if (!origin_sent) begin
                origin_sent = 1'b1;
            end else if (walk_x < stop_x) begin
                walk_x = walk_x + 13'sd1;
                // zero decision goes north-east
                if (decision < 0) begin
                    decision = decision + east_step;
                end else begin
                    walk_y   = walk_y + 13'sd1;
                    decision = decision + diag_step;
                end
            end
            want.last = (walk_x >= stop_x);
            if (want.last) drawing = 1'b0;
            unfold(zone, walk_x, walk_y, px, py);
            want.x    = px[COORD_W-1:0];
            want.y    = py[COORD_W-1:0];
            want.zone = zone;
            pending_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 100) $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                         logic [2:0] z, logic last);
            t_pixel want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                          $signed(px), $signed(py)));
                return;
            end
            want = pending_q.pop_front();
            if (px !== want.x)
                report_mismatch($sformatf("pixel_x got %0d want %0d",
                                          $signed(px), $signed(want.x)));
            if (py !== want.y)
                report_mismatch($sformatf("pixel_y got %0d want %0d",
                                          $signed(py), $signed(want.y)));
            if (z !== want.zone)
                report_mismatch($sformatf("octant got %0d want %0d", z, want.zone));
            if (last !== want.last)
                report_mismatch($sformatf("last_point got %0b want %0b", last, want.last));
        endtask
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata  = '0;   // x_start, y_start, x_end, y_end
    logic             i_s_tuser  = 1'b0; // action
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;         // pixel_x, pixel_y
    logic [2:0]       o_m_tuser;         // octant
    logic             o_m_tlast;         // last_point

    pixel_scoreboard sb;
    int              cycle_count   = 0;
    int              request_count = 0;
    int              sink_hold     = 0;
    bit              calm_sink     = 1'b0;
    bit              calm_sender   = 1'b0;

    midpoint_line_rasterizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, 17));
    endfunction

    always @(posedge i_clk) begin
        if (cycle_count % 256 == 0) calm_sink = ($urandom_range(0, 3) == 0);
        if (o_m_tvalid && i_m_tready) sink_hold = pick_gap(calm_sink);
        else if (sink_hold > 0) sink_hold--;
        i_m_tready <= (sink_hold == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_pixel(o_m_tdata[COORD_W-1:0], o_m_tdata[2*COORD_W-1:COORD_W],
                               o_m_tuser, o_m_tlast);
            if (i_s_tvalid && o_s_tready)
                sb.note_request(mlr_pkg::t_action'(i_s_tuser), i_s_tdata);
        end
    end

    function automatic logic [IN_W-1:0] noise_word();
        return IN_W'({$urandom(), $urandom()});
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic int line_span(int x0, int y0, int x1, int y1);
        int ax;
        int ay;
        ax = (x1 > x0) ? x1 - x0 : x0 - x1;
        ay = (y1 > y0) ? y1 - y0 : y0 - y1;
        return ((ax > ay) ? ax : ay) + 1;
    endfunction

    // called at a rising edge; valid is only dropped for a gap before the request
    task automatic send_request(mlr_pkg::t_action act, logic [IN_W-1:0] data);
        int gap;
        gap = pick_gap(calm_sender);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic trace_line(int x0, int y0, int x1, int y1, int steps);
        send_request(mlr_pkg::ACT_LOAD, IN_W'({COORD_W'(y1), COORD_W'(x1),
                                               COORD_W'(y0), COORD_W'(x0)}));
        repeat (steps) send_request(mlr_pkg::ACT_STEP, noise_word());
        request_count += steps + 1;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int x0, y0, x1, y1;
        int dx, dy;
        int pick, shape, reach, steps, line_count;
        sb = new();
        line_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // step before any load, then a single-pixel line at the corner
        send_request(mlr_pkg::ACT_STEP, noise_word());
        request_count++;
        trace_line(-2048, 2047, -2048, 2047, 2);
        // decision hits zero on the first move
        trace_line(0, 0, 2, 1, 3);
        // diagonals land in the steep zones
        trace_line(5, 5, 6, 6, 2);
        trace_line(-3, 4, -4, 5, 2);
        trace_line(0, 0, -1, -1, 2);
        trace_line(10, -10, 11, -11, 2);
        // full-range lines, the second load cuts the first one short
        trace_line(-2048, -2048, 2047, 2047, 2);
        trace_line(2047, -2048, -2048, 2047, 2);
        wait_drained();

        while (request_count < ITEM_TARGET) begin
            if (line_count % 16 == 0) calm_sender = ($urandom_range(0, 3) == 0);
            if (line_count % 60 == 59) wait_drained();
            line_count++;
            pick = $urandom_range(0, 99);
            x0 = rand_coord();
            y0 = rand_coord();
            if (pick < 10) begin
                trace_line(x0, y0, rand_coord(), rand_coord(), $urandom_range(1, 6));
            end else if (pick < 18) begin
                send_request(mlr_pkg::ACT_STEP, noise_word());
                request_count++;
            end else begin
                reach = (pick < 24) ? 120 : 24;
                dx = int'($urandom_range(0, 2 * reach)) - reach;
                dy = int'($urandom_range(0, 2 * reach)) - reach;
                shape = $urandom_range(0, 9);
                if (shape == 0) begin
                    dy = $urandom_range(0, 1) ? dx : -dx;
                end else if (shape == 1) begin
                    dx = 0;
                    dy = 0;
                end
                x1 = clamp_coord(x0 + dx);
                y1 = clamp_coord(y0 + dy);
                steps = line_span(x0, y0, x1, y1);
                shape = $urandom_range(0, 9);
                if (shape == 0) steps++;
                else if (shape == 1) steps = $urandom_range(0, steps - 1);
                trace_line(x0, y0, x1, y1, steps);
            end
        end

        wait_drained();
        if (sb.pending_q.size() != 0) sb.report_mismatch("predicted pixels never arrived");
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/mlr_pkg.sv
design/midpoint_line_rasterizer_top.sv
design/mlr_checker.sv
dv/tb_midpoint_line_rasterizer_top.sv
